>>> sv/pfba_pkg.sv
// Shared types, sizes and codes for the page frame bitmap allocator.
package pfba_pkg;

	localparam int NUM_FRAMES   = 4096;
	localparam int FRAME_BYTES  = 4096;
	localparam int PAGE_SHIFT   = $clog2(FRAME_BYTES);
	localparam int ADDR_W       = 24;
	localparam int COUNT_W      = 13;
	localparam int OP_W         = 2;
	localparam int STATUS_W     = 2;
	localparam int FRAME_W      = $clog2(NUM_FRAMES);
	localparam int ADDR_FRAME_W = ADDR_W - PAGE_SHIFT;
	localparam int SUM_W        = ((ADDR_FRAME_W > COUNT_W) ? ADDR_FRAME_W : COUNT_W) + 1;
	localparam int WORD_W       = 32;
	localparam int BIT_IDX_W    = $clog2(WORD_W);
	localparam int MAP_WORDS    = NUM_FRAMES / WORD_W;
	localparam int WORD_IDX_W   = $clog2(MAP_WORDS);
	localparam int CHUNK_W      = 8;
	localparam int CHUNK_POS_W  = $clog2(CHUNK_W);
	localparam int CHUNKS       = WORD_W / CHUNK_W;
	localparam int CHUNK_IDX_W  = $clog2(CHUNKS);

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_RUN   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_PAST_END = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [COUNT_W-1:0] frame_count;
		logic [ADDR_W-1:0]  base_address;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   run_address;
	} rsp_t;

	typedef struct packed {
		logic                  rd_en;
		logic [WORD_IDX_W-1:0] rd_addr;
		logic                  wr_en;
		logic [WORD_IDX_W-1:0] wr_addr;
		logic [WORD_W-1:0]     wr_data;
	} map_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_DONE
	} state_t;

endpackage

>>> sv/pfba_map.sv
// Used-frame bitmap store: word memory with per-word valid bits that read as all used.
module pfba_map (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pfba_pkg::map_req_t                 map_req,
	output logic [pfba_pkg::WORD_W-1:0]        rd_word
);
	import pfba_pkg::*;

	logic [WORD_W-1:0]    mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] row_valid_q;
	logic [WORD_W-1:0]    rd_data_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (map_req.wr_en)
				row_valid_q[map_req.wr_addr] <= 1'b1;
			if (map_req.rd_en)
				rd_valid_q <= row_valid_q[map_req.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (map_req.wr_en)
			mem[map_req.wr_addr] <= map_req.wr_data;
		if (map_req.rd_en)
			rd_data_q <= mem[map_req.rd_addr];
	end

	// never-written words read as all ones: every frame used
	assign rd_word = rd_valid_q ? rd_data_q : '1;

endmodule

>>> sv/page_frame_bitmap_allocator.sv
// Top level of the first-fit bitmap page frame allocator.
// One request is worked at a time. Release and reserve read then write each
// 32-frame word of the run. Allocate scans the bitmap 8 frames per cycle up to the
// end of the first fitting run, then marks the run word by word; a scan that finds
// no run ends at the last word. Zero counts, unknown ops and rejected runs go
// straight to the result. The bitmap memory read is registered, which makes every
// marked word a read then a write.
// The result waits in an output register, so a new request is taken as soon as
// the previous one has left the datapath.
module page_frame_bitmap_allocator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  pfba_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output pfba_pkg::rsp_t  rsp
);
	import pfba_pkg::*;

	state_t state_q, state_d;

	logic [COUNT_W-1:0]     count_q;
	logic [COUNT_W-1:0]     run_q;
	logic [WORD_IDX_W-1:0]  word_q;
	logic [CHUNK_IDX_W-1:0] chunk_q;
	logic [FRAME_W-1:0]     first_q;
	logic [FRAME_W-1:0]     last_q;
	logic                   set_q;
	logic [STATUS_W-1:0]    res_status_q;
	logic [ADDR_W-1:0]      res_addr_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	map_req_t           map_req;
	logic [WORD_W-1:0]  rd_word;

	logic                    acc;
	logic                    cnt_zero;
	logic                    too_big;
	logic [ADDR_FRAME_W-1:0] req_first;
	logic                    past_end;
	logic [FRAME_W-1:0]      req_last;
	logic [CHUNK_W-1:0]      chunk;
	logic [COUNT_W-1:0]      run_v;
	logic                    hit;
	logic [CHUNK_POS_W-1:0]  hit_pos;
	logic [FRAME_W-1:0]      hit_last;
	logic [FRAME_W-1:0]      hit_first;
	logic                    last_word;
	logic                    mark_last;
	logic [BIT_IDX_W-1:0]    lo_bit;
	logic [BIT_IDX_W-1:0]    hi_bit;
	logic [WORD_W-1:0]       mask;
	logic                    rsp_load;

	pfba_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.map_req (map_req),
		.rd_word (rd_word)
	);

	assign acc       = req_valid && req_ready;
	assign cnt_zero  = (req.frame_count == '0);
	assign too_big   = (SUM_W'(req.frame_count) > SUM_W'(NUM_FRAMES));
	assign req_first = req.base_address[ADDR_W-1:PAGE_SHIFT];
	assign past_end  = (SUM_W'(req_first) + SUM_W'(req.frame_count)) > SUM_W'(NUM_FRAMES);
	assign req_last  = FRAME_W'(SUM_W'(req_first) + SUM_W'(req.frame_count) - SUM_W'(1));

	// scan one slice of the current word, chaining the free-run length
	assign chunk = rd_word[{chunk_q, CHUNK_POS_W'(0)} +: CHUNK_W];

	always_comb begin
		run_v   = run_q;
		hit     = 1'b0;
		hit_pos = '0;
		for (int j = 0; j < CHUNK_W; j++) begin
			if (!hit) begin
				if (chunk[j])
					run_v = '0;
				else
					run_v = run_v + COUNT_W'(1);
				if (!chunk[j] && run_v == count_q) begin
					hit     = 1'b1;
					hit_pos = CHUNK_POS_W'(j);
				end
			end
		end
	end

	assign hit_last  = {word_q, chunk_q, hit_pos};
	assign hit_first = FRAME_W'(COUNT_W'(hit_last) + COUNT_W'(1) - count_q);
	assign last_word = (word_q == WORD_IDX_W'(MAP_WORDS - 1));
	assign mark_last = (word_q == last_q[FRAME_W-1:BIT_IDX_W]);

	assign lo_bit = (word_q == first_q[FRAME_W-1:BIT_IDX_W]) ? first_q[BIT_IDX_W-1:0] : '0;
	assign hi_bit = mark_last ? last_q[BIT_IDX_W-1:0] : '1;
	assign mask   = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (BIT_IDX_W'(WORD_W - 1) - hi_bit));

	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (cnt_zero)
						state_d = ST_DONE;
					else begin
						unique case (req.op)
							OP_ALLOC:   state_d = too_big ? ST_DONE : ST_SCAN_RD;
							OP_RELEASE,
							OP_RESERVE: state_d = past_end ? ST_DONE : ST_MARK_RD;
							default:    state_d = ST_DONE;
						endcase
					end
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (hit)
					state_d = ST_MARK_RD;
				else if (chunk_q == CHUNK_IDX_W'(CHUNKS - 1) && last_word)
					state_d = ST_DONE;
			end
			ST_MARK_RD: state_d = ST_MARK_WR;
			ST_MARK_WR: state_d = mark_last ? ST_DONE : ST_MARK_RD;
			ST_DONE:    if (rsp_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready       = 1'b0;
		map_req.rd_en   = 1'b0;
		map_req.rd_addr = word_q;
		map_req.wr_en   = 1'b0;
		map_req.wr_addr = word_q;
		map_req.wr_data = set_q ? (rd_word | mask) : (rd_word & ~mask);
		unique case (state_q)
			ST_IDLE:    req_ready = 1'b1;
			ST_SCAN_RD: map_req.rd_en = 1'b1;
			ST_SCAN: begin
				// prefetch the next word while the last slice is scanned
				if (chunk_q == CHUNK_IDX_W'(CHUNKS - 1)) begin
					map_req.rd_en   = 1'b1;
					map_req.rd_addr = word_q + WORD_IDX_W'(1);
				end
			end
			ST_MARK_RD: map_req.rd_en = 1'b1;
			ST_MARK_WR: map_req.wr_en = 1'b1;
			ST_DONE:    ;
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					count_q    <= req.frame_count;
					run_q      <= '0;
					chunk_q    <= '0;
					res_addr_q <= '0;
					first_q    <= FRAME_W'(req_first);
					last_q     <= req_last;
					set_q      <= (req.op != OP_RELEASE);
					word_q     <= (req.op == OP_ALLOC) ? '0
					              : WORD_IDX_W'(req_first >> BIT_IDX_W);
					if (!cnt_zero && req.op == OP_ALLOC && too_big)
						res_status_q <= STAT_NO_RUN;
					else if (!cnt_zero && (req.op == OP_RELEASE || req.op == OP_RESERVE)
					         && past_end)
						res_status_q <= STAT_PAST_END;
					else
						res_status_q <= STAT_OK;
				end
			end
			ST_SCAN: begin
				run_q   <= run_v;
				chunk_q <= chunk_q + CHUNK_IDX_W'(1);
				if (hit) begin
					first_q    <= hit_first;
					last_q     <= hit_last;
					word_q     <= hit_first[FRAME_W-1:BIT_IDX_W];
					res_addr_q <= ADDR_W'(ADDR_W'(hit_first) << PAGE_SHIFT);
				end else if (chunk_q == CHUNK_IDX_W'(CHUNKS - 1)) begin
					if (last_word)
						res_status_q <= STAT_NO_RUN;
					else
						word_q <= word_q + WORD_IDX_W'(1);
				end
			end
			ST_MARK_WR: word_q <= word_q + WORD_IDX_W'(1);
			ST_DONE: begin
				if (rsp_load) begin
					rsp_q.status      <= res_status_q;
					rsp_q.run_address <= res_addr_q;
				end
			end
			ST_SCAN_RD, ST_MARK_RD: ;
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> sv/pfba_checker.sv
// Port-level checks for the page frame bitmap allocator, bound to the top level.
module pfba_port_checks (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input pfba_pkg::req_t  req,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input pfba_pkg::rsp_t  rsp
);
	import pfba_pkg::*;

	// result item holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item dropped or changed while stalled");

	// one request at a time: no accept directly after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == STAT_OK || rsp.status == STAT_NO_RUN ||
		              rsp.status == STAT_PAST_END)
		else $error("undefined status code");

	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STAT_OK |-> rsp.run_address == '0)
		else $error("failed request returned an address");

	a_page_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.run_address[PAGE_SHIFT-1:0] == '0)
		else $error("run address not page aligned");

endmodule

bind page_frame_bitmap_allocator pfba_port_checks u_pfba_checker (.*);

>>> dv/pfba_checker.sv
`timescale 1ns / 1ps
// Checker for the page frame bitmap allocator: tracks the frame map, predicts each result and compares.
module pfba_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  pfba_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  pfba_pkg::rsp_t rsp,
	output int             mismatches,
	output int             pending,
	output int             results_seen,
	output int             runs_granted
);
	import pfba_pkg::*;

	logic [NUM_FRAMES-1:0] frame_used;
	rsp_t                  expected_rsp_q[$];
	rsp_t                  want;
	int                    bad_cnt;
	int                    done_cnt;
	int                    grant_cnt;

	// Updates frame_used for one request and returns the result it should give.
	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		int   cnt;
		int   run;
		int   first;
		int   i;
		o.status      = STAT_OK;
		o.run_address = '0;
		cnt           = int'(r.frame_count);
		if (cnt != 0) begin
			if (r.op == OP_ALLOC) begin
				o.status = STAT_NO_RUN;
				run      = 0;
				if (cnt <= NUM_FRAMES) begin
					for (int f = 0; f < NUM_FRAMES; f++) begin
						if (frame_used[f]) begin
							run = 0;
						end else begin
							run++;
							if (run == cnt) begin
								first = f + 1 - cnt;
								for (i = 0; i < cnt; i++)
									frame_used[first + i] = 1'b1;
								o.run_address = ADDR_W'(first * FRAME_BYTES);
								o.status      = STAT_OK;
								grant_cnt++;
								break;
							end
						end
					end
				end
			end else if (r.op == OP_RELEASE || r.op == OP_RESERVE) begin
				first = int'(r.base_address >> PAGE_SHIFT);
				if (first + cnt > NUM_FRAMES) begin
					o.status = STAT_PAST_END;
				end else begin
					for (i = 0; i < cnt; i++)
						frame_used[first + i] = (r.op == OP_RESERVE);
				end
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_used = '1;
			expected_rsp_q.delete();
			bad_cnt      = 0;
			done_cnt     = 0;
			grant_cnt    = 0;
			mismatches   <= 0;
			pending      <= 0;
			results_seen <= 0;
			runs_granted <= 0;
		end else begin
			// results first: a request taken at this edge cannot have produced one yet
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					bad_cnt++;
					if (bad_cnt <= 10)
						$display("result %0d with none outstanding: status %0d run_address %06h",
							done_cnt, rsp.status, rsp.run_address);
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.status !== want.status || rsp.run_address !== want.run_address) begin
						bad_cnt++;
						if (bad_cnt <= 10)
							$display("result %0d: status exp %0d got %0d, run_address exp %06h got %06h",
								done_cnt, want.status, rsp.status, want.run_address,
								rsp.run_address);
					end
				end
				done_cnt++;
			end
			if (req_valid && req_ready)
				expected_rsp_q.push_back(apply_request(req));
			mismatches   <= bad_cnt;
			pending      <= expected_rsp_q.size();
			results_seen <= done_cnt;
			runs_granted <= grant_cnt;
		end
	end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request and response traffic, verdict.
module testbench;
	import pfba_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int BLOCK_ITEMS   = 50;
	localparam int RANDOM_BLOCKS = 19;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 1000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	int mismatches;
	int pending;
	int results_seen;
	int runs_granted;
	bit idle_on;
	bit hold_off_req;
	int op_sent[4];

	page_frame_bitmap_allocator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	pfba_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.pending     (pending),
		.results_seen(results_seen),
		.runs_granted(runs_granted)
	);

	always #6 clk = ~clk;

	function automatic req_t make_req(logic [OP_W-1:0] op, int cnt, int addr);
		req_t r;
		r.op           = op;
		r.frame_count  = COUNT_W'(cnt);
		r.base_address = ADDR_W'(addr);
		return r;
	endfunction

	// Mostly small runs; a few large and oversize ones, some placed right at the top frame.
	function automatic req_t random_request();
		req_t            r;
		int              pick;
		int              cnt;
		int              frame;
		logic [OP_W-1:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 42)
			op = OP_ALLOC;
		else if (pick < 72)
			op = OP_RELEASE;
		else if (pick < 94)
			op = OP_RESERVE;
		else
			op = OP_UNUSED;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			cnt = 0;
		else if (pick < 73)
			cnt = $urandom_range(1, 16);
		else if (pick < 93)
			cnt = $urandom_range(17, 256);
		else if (pick < 97)
			cnt = $urandom_range(257, NUM_FRAMES);
		else
			cnt = $urandom_range(NUM_FRAMES + 1, (1 << COUNT_W) - 1);
		if ($urandom_range(0, 9) < 2 && cnt <= NUM_FRAMES) begin
			frame = NUM_FRAMES - cnt + $urandom_range(0, 2) - 1;
			if (frame < 0)
				frame = 0;
			if (frame > NUM_FRAMES - 1)
				frame = NUM_FRAMES - 1;
			r = make_req(op, cnt, frame * FRAME_BYTES + $urandom_range(0, FRAME_BYTES - 1));
		end else begin
			r = make_req(op, cnt, $urandom_range(0, (1 << ADDR_W) - 1));
		end
		return r;
	endfunction

	task automatic send(req_t r);
		int gap;
		gap = idle_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		op_sent[r.op]++;
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		clk          = 1'b0;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		rsp_ready    = 1'b0;
		idle_on      = 1'b1;
		hold_off_req = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: everything starts used
		send(make_req(OP_ALLOC, 1, 0));
		send(make_req(OP_RELEASE, 0, 24'h123456));
		send(make_req(OP_UNUSED, 5, 24'h004000));
		send(make_req(OP_RELEASE, NUM_FRAMES, 0));
		send(make_req(OP_ALLOC, NUM_FRAMES, 0));
		send(make_req(OP_ALLOC, 1, 0));
		send(make_req(OP_RELEASE, 1, 24'hFFFFFF));
		send(make_req(OP_RELEASE, 2, 24'hFFF000));
		send(make_req(OP_ALLOC, (1 << COUNT_W) - 1, 0));
		send(make_req(OP_ALLOC, 1, 24'hABCDEF));
		// a gap of used frames must restart the run count
		send(make_req(OP_RELEASE, 3, 24'h000FFF));
		send(make_req(OP_RELEASE, 4, 24'h005000));
		send(make_req(OP_ALLOC, 4, 0));
		send(make_req(OP_ALLOC, 3, 0));
		send(make_req(OP_RELEASE, 3, 0));
		send(make_req(OP_RELEASE, 3, 0));
		send(make_req(OP_RESERVE, 1, 24'h001000));
		send(make_req(OP_ALLOC, 2, 0));
		send(make_req(OP_RESERVE, 4, 24'h005000));
		send(make_req(OP_RESERVE, NUM_FRAMES, 24'h800000));
		send(make_req(OP_RESERVE, 0, 24'hFFFFFF));
		send(make_req(OP_UNUSED, (1 << COUNT_W) - 1, 24'hFFFFFF));
		send(make_req(OP_RELEASE, NUM_FRAMES, 0));
		send(make_req(OP_ALLOC, NUM_FRAMES + 1, 0));
		send(make_req(OP_RELEASE, NUM_FRAMES / 2, 0));
		wait_drained();

		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			idle_on = (blk % 4) != 2;
			if (blk == 5)
				hold_off_req = 1'b1;
			// each block opens by freeing one aligned region so allocations keep finding room
			send(make_req(OP_RELEASE, 512, $urandom_range(0, 7) * 512 * FRAME_BYTES));
			for (int i = 0; i < BLOCK_ITEMS; i++)
				send(random_request());
			if (blk == 10)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d items: %0d allocate (%0d granted), %0d release, %0d reserve, %0d unused op",
			op_sent[0] + op_sent[1] + op_sent[2] + op_sent[3], op_sent[OP_ALLOC], runs_granted,
			op_sent[OP_RELEASE], op_sent[OP_RESERVE], op_sent[OP_UNUSED]);
		$display("%0d results compared, %0d mismatched; long output stall and full drains included",
			results_seen, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : receiver
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			gap = idle_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin : watchdog
		#50_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
sv/pfba_pkg.sv
sv/pfba_map.sv
sv/page_frame_bitmap_allocator.sv
sv/pfba_checker.sv
dv/pfba_checker.sv
dv/testbench.sv
